[design/lcr_pkg.sv]
// ----------------------------------------------------------------------------
// lcr_pkg: shared types and constants of the load current regulator
// command and status words between controller and datapath, register codes,
// fixed widths and reciprocal constants for the exact divisions by 10 and 3
// ----------------------------------------------------------------------------
package lcr_pkg;

  // converter and field widths
  localparam int unsigned SMP_W   = 12;
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned CF_W    = 22;  // current filter, signed q8
  localparam int unsigned VF_W    = 24;  // voltage filter, signed q8
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 14;

  // shared multiplier
  localparam int unsigned MUL_W  = 26;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // exact truncating division by reciprocal: q = (n * recip) >> shift
  localparam logic [22:0] RECIP10 = 23'd3355444;   // ceil(2^25 / 10), n < 2^21
  localparam int unsigned SHIFT10 = 25;
  localparam logic [24:0] RECIP3  = 25'd22369622;  // ceil(2^26 / 3), n < 2^24
  localparam int unsigned SHIFT3  = 26;

  // register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_SENSE_OFFSET  = 3'd1,
    REG_LOOP_GAIN     = 3'd2,
    REG_VOLT_COMP     = 3'd3,
    REG_CUTOFF_LEVEL  = 3'd4,
    REG_TRIP_DELTA    = 3'd5,
    REG_RELEASE_DELTA = 3'd6,
    REG_FEATURES      = 3'd7
  } cfg_reg_e;

  // one step command from the controller, at most one bit set
  typedef struct packed {
    logic load;     // capture the input word
    logic mul_cf;   // current error times 1/10
    logic upd_cf;   // current filter update
    logic mul_vc;   // volt_comp times current filter
    logic mul_acc;  // voltage target, gain times error
    logic mul_vf;   // tentative drive, voltage error times 2/3
    logic upd_vf;   // voltage filter update
    logic commit;   // limits, cutoff, thermal, output register load
  } lcr_cmd_t;

  typedef struct packed {
    logic stopped;
  } lcr_stat_t;

endpackage

[design/lcr_ctrl.sv]
// ----------------------------------------------------------------------------
// lcr_ctrl: sequencer of the load current regulator
// walks one word through the datapath steps and owns both handshakes
// ----------------------------------------------------------------------------
module lcr_ctrl
  import lcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lcr_stat_t stat_i,
  output lcr_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MCF  = 8'b0000_0010,
    ST_UCF  = 8'b0000_0100,
    ST_MVC  = 8'b0000_1000,
    ST_MACC = 8'b0001_0000,
    ST_MVF  = 8'b0010_0000,
    ST_UVF  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   take_in, commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign take_in     = in_valid_i & in_ready_o;
  assign commit      = (state_q == ST_FIN) & (~ovalid_q | out_ready_i);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take_in) begin
          state_d = stat_i.stopped ? ST_FIN : ST_MCF;
        end
      end
      ST_MCF:  state_d = ST_UCF;
      ST_UCF:  state_d = ST_MVC;
      ST_MVC:  state_d = ST_MACC;
      ST_MACC: state_d = ST_MVF;
      ST_MVF:  state_d = ST_UVF;
      ST_UVF:  state_d = ST_FIN;
      ST_FIN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (commit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = take_in;
    cmd_o.mul_cf  = (state_q == ST_MCF);
    cmd_o.upd_cf  = (state_q == ST_UCF);
    cmd_o.mul_vc  = (state_q == ST_MVC);
    cmd_o.mul_acc = (state_q == ST_MACC);
    cmd_o.mul_vf  = (state_q == ST_MVF);
    cmd_o.upd_vf  = (state_q == ST_UVF);
    cmd_o.commit  = commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

[design/lcr_datapath.sv]
// ----------------------------------------------------------------------------
// lcr_datapath: registers, filters and drive arithmetic of the regulator
// one shared signed multiplier, product register, filter and drive state,
// configuration registers and the result register
// ----------------------------------------------------------------------------
module lcr_datapath
  import lcr_pkg::*;
#(
  parameter int unsigned PWM_LIMIT = 4000
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcr_cmd_t                cmd_i,
  output lcr_stat_t               stat_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i,
  input  logic [SMP_W-1:0]        current_sample_i,
  input  logic [SMP_W-1:0]        voltage_sample_i,
  input  logic signed [TEMP_W-1:0] temperature_i,
  output logic [11:0]             pwm_duty_o,
  output logic                    stopped_o,
  output logic                    fan_on_o,
  output logic signed [12:0]      measured_current_o,
  output logic [13:0]             filtered_voltage_o
);

  localparam int unsigned LIMIT_Q8 = PWM_LIMIT * 256;
  localparam int unsigned ACC_BITS = $clog2(LIMIT_Q8 + 1);
  localparam int unsigned ACC_W    = (ACC_BITS > 20) ? ACC_BITS : 20;
  localparam int unsigned SUM_W    = ((ACC_W > 24) ? ACC_W : 24) + 2;
  localparam logic [ACC_W-1:0] LIMIT_ACC = ACC_W'(LIMIT_Q8);

  // configuration
  logic [11:0]        setpoint_q, offset_q;
  logic [9:0]         gain_q;
  logic signed [9:0]  vcomp_q;
  logic [13:0]        cutoff_q;
  logic [7:0]         trip_q, release_q;
  logic [1:0]         feat_q;

  // captured word
  logic [SMP_W-1:0]         si_q, sv_q;
  logic signed [TEMP_W-1:0] temp_q;

  // block state
  logic signed [CF_W-1:0]   cf_q, cf_d;
  logic signed [VF_W-1:0]   vf_q, vf_d;
  logic [ACC_W-1:0]         acc_q;
  logic                     stop_q, bvalid_q, tripped_q;
  logic signed [TEMP_W-1:0] base_q;

  // step registers
  logic signed [PROD_W-1:0] p_q, p_d;
  logic signed [VF_W-1:0]   tgt_q, tgt_d;
  logic [ACC_W-1:0]         accs_q, accs_d;
  logic                     sgn_q, sgn_d;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [12:0]       diff;
  logic signed [CF_W-1:0]   ecur, eacc, qcf;
  logic [20:0]              ecur_abs;
  logic [20:0]              q10;
  logic signed [VF_W:0]     dv, dv_abs;
  logic [22:0]              q3;
  logic signed [VF_W-1:0]   qvf;
  logic signed [SUM_W-1:0]  acc_sum, lim_ext;

  // commit step
  logic [ACC_W-1:0]         acc_n;
  logic                     stop_n, trip_n, bvalid_n, cut;
  logic signed [TEMP_W-1:0] base_n;
  logic signed [12:0]       tdiff, tabs;
  logic [7:0]               thr;

  assign stat_o.stopped = stop_q;

  // current error and drive error
  assign diff     = $signed({1'b0, si_q}) - $signed({1'b0, offset_q});
  assign ecur     = $signed({diff[12], diff, 8'h00}) - cf_q;
  assign ecur_abs = ecur[CF_W-1] ? 21'(-ecur) : ecur[20:0];
  assign eacc     = $signed({2'b00, setpoint_q, 8'h00}) - cf_q;

  // voltage error against the stored target
  assign dv     = $signed({tgt_q[VF_W-1], tgt_q}) - $signed({vf_q[VF_W-1], vf_q});
  assign dv_abs = dv[VF_W] ? -dv : dv;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sgn_d = sgn_q;
    if (cmd_i.mul_cf) begin
      mul_a = {5'b0, ecur_abs};
      mul_b = {3'b0, RECIP10};
      sgn_d = ecur[CF_W-1];
    end else if (cmd_i.mul_vc) begin
      mul_a = {{16{vcomp_q[9]}}, vcomp_q};
      mul_b = {{4{cf_q[CF_W-1]}}, cf_q};
    end else if (cmd_i.mul_acc) begin
      mul_a = {16'b0, gain_q};
      mul_b = {{4{eacc[CF_W-1]}}, eacc};
    end else if (cmd_i.mul_vf) begin
      mul_a = {1'b0, dv_abs[VF_W-1:0], 1'b0};  // twice the error
      mul_b = {1'b0, RECIP3};
      sgn_d = dv[VF_W];
    end
    p_d = mul_a * mul_b;
  end

  // current filter, truncation toward zero through the sign kept aside
  assign q10  = p_q[SHIFT10 +: 21];
  assign qcf  = sgn_q ? -$signed({1'b0, q10}) : $signed({1'b0, q10});
  assign cf_d = cf_q + qcf;

  // voltage target: doubled sample plus floored compensation
  assign tgt_d = $signed({3'b000, sv_q, 9'h000}) + $signed(p_q[31:8]);

  // tentative drive: accumulate, zero, clamp
  assign lim_ext = $signed({{(SUM_W-ACC_W){1'b0}}, LIMIT_ACC});
  assign acc_sum = $signed({{(SUM_W-ACC_W){1'b0}}, acc_q})
                 + $signed({{(SUM_W-24){p_q[31]}}, p_q[31:8]});
  always_comb begin
    if (acc_sum[SUM_W-1] || cf_q[CF_W-1] || (setpoint_q == 12'd0)) begin
      accs_d = '0;
    end else if (acc_sum > lim_ext) begin
      accs_d = LIMIT_ACC;
    end else begin
      accs_d = acc_sum[ACC_W-1:0];
    end
  end

  // voltage filter
  assign q3   = p_q[SHIFT3 +: 23];
  assign qvf  = sgn_q ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
  assign vf_d = vf_q + qvf;

  // cutoff, thermal check and final drive
  assign tdiff = $signed({base_q[TEMP_W-1], base_q}) - $signed({temp_q[TEMP_W-1], temp_q});
  assign tabs  = tdiff[12] ? -tdiff : tdiff;
  assign thr   = tripped_q ? release_q : trip_q;
  assign cut   = feat_q[0] && (setpoint_q != 12'd0)
              && (vf_q <= $signed({2'b00, cutoff_q, 8'h00}));

  always_comb begin
    acc_n    = acc_q;
    stop_n   = stop_q;
    trip_n   = tripped_q;
    bvalid_n = bvalid_q;
    base_n   = base_q;
    if (!stop_q) begin
      acc_n = accs_q;
      if (cut) begin
        acc_n  = '0;
        stop_n = 1'b1;
      end
      if (!bvalid_q) begin
        base_n   = temp_q;
        bvalid_n = 1'b1;
      end else if (feat_q[1]) begin
        if ($unsigned(tabs) > {5'b0, thr}) begin
          acc_n  = '0;
          trip_n = 1'b1;
        end else begin
          trip_n = 1'b0;
        end
      end else begin
        trip_n = 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= 12'd0;
      offset_q   <= 12'd0;
      gain_q     <= 10'd63;
      vcomp_q    <= 10'sd0;
      cutoff_q   <= 14'd3008;
      trip_q     <= 8'd16;
      release_q  <= 8'd8;
      feat_q     <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SETPOINT:      setpoint_q <= cfg_data_i[11:0];
        REG_SENSE_OFFSET:  offset_q   <= cfg_data_i[11:0];
        REG_LOOP_GAIN:     gain_q     <= cfg_data_i[9:0];
        REG_VOLT_COMP:     vcomp_q    <= $signed(cfg_data_i[9:0]);
        REG_CUTOFF_LEVEL:  cutoff_q   <= cfg_data_i[13:0];
        REG_TRIP_DELTA:    trip_q     <= cfg_data_i[7:0];
        REG_RELEASE_DELTA: release_q  <= cfg_data_i[7:0];
        REG_FEATURES:      feat_q     <= cfg_data_i[1:0];
      endcase
    end
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q      <= '0;
      vf_q      <= '0;
      acc_q     <= '0;
      stop_q    <= 1'b0;
      bvalid_q  <= 1'b0;
      base_q    <= '0;
      tripped_q <= 1'b0;
    end else begin
      if (cmd_i.upd_cf) begin
        cf_q <= cf_d;
      end
      if (cmd_i.upd_vf) begin
        vf_q <= vf_d;
      end
      if (cmd_i.commit) begin
        acc_q     <= acc_n;
        stop_q    <= stop_n;
        bvalid_q  <= bvalid_n;
        base_q    <= base_n;
        tripped_q <= trip_n;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      si_q   <= current_sample_i;
      sv_q   <= voltage_sample_i;
      temp_q <= temperature_i;
    end
    if (cmd_i.mul_cf || cmd_i.mul_vc || cmd_i.mul_acc || cmd_i.mul_vf) begin
      p_q   <= p_d;
      sgn_q <= sgn_d;
    end
    if (cmd_i.mul_acc) begin
      tgt_q <= tgt_d;
    end
    if (cmd_i.mul_vf) begin
      accs_q <= accs_d;
    end
    if (cmd_i.commit) begin
      pwm_duty_o         <= acc_n[19:8];
      stopped_o          <= stop_n;
      fan_on_o           <= trip_n;
      measured_current_o <= cf_q[20:8];
      if (vf_q[VF_W-1]) begin
        filtered_voltage_o <= 14'd0;
      end else if (vf_q[22]) begin
        filtered_voltage_o <= 14'h3FFF;
      end else begin
        filtered_voltage_o <= vf_q[21:8];
      end
    end
  end

endmodule

[design/load_current_regulator.sv]
// ----------------------------------------------------------------------------
// load_current_regulator: incremental pi current controller for an electronic load
// filters current and voltage samples, integrates the current error into a
// pwm drive, with low-voltage cutoff and thermal rise protection
// ----------------------------------------------------------------------------
// One input word is one control tick: raw current and voltage converter samples
// plus a temperature. Each tick gives exactly one result word with the pwm duty,
// the stop and fan flags, and the integer parts of both filters. A tick steps
// through current filter multiply and update, compensation multiply, target and
// gain multiply, voltage filter multiply and update, and commit; the result word
// turns valid in the same cycle as the input side turns ready. The multiply steps
// share one signed 26 x 26 multiplier (filter divisions by 10 and 3 are reciprocal
// multiplies). Once the voltage cutoff has latched a stop, a tick goes straight to
// commit and repeats the frozen values with pwm 0; only reset clears the stop. The
// input side is ready whenever the sequencer is idle, also while the previous
// result still waits in the output register; a finished tick holds in its last
// step until that register is free. The user writes registers through the plain
// write port only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module load_current_regulator
  import lcr_pkg::*;
#(
  parameter int unsigned PWM_LIMIT = 4000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // sample stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // current_sample[11:0], voltage_sample[23:12], temperature[35:24], zero pad
  input  logic [39:0]          s_axis_tdata_i,
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // pwm_duty[11:0], stopped[12], fan_on[13], measured_current[26:14],
  // filtered_voltage[40:27], zero pad
  output logic [47:0]          m_axis_tdata_o
);

  lcr_cmd_t  cmd;
  lcr_stat_t stat;

  logic [11:0]        pwm_duty;
  logic               stopped, fan_on;
  logic signed [12:0] measured_current;
  logic [13:0]        filtered_voltage;

  // sequencer: one step per cycle unless a handshake on either side holds it
  lcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // filters, drive accumulator, protection state and result register
  lcr_datapath #(
    .PWM_LIMIT (PWM_LIMIT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .current_sample_i   (s_axis_tdata_i[11:0]),
    .voltage_sample_i   (s_axis_tdata_i[23:12]),
    .temperature_i      ($signed(s_axis_tdata_i[35:24])),
    .pwm_duty_o         (pwm_duty),
    .stopped_o          (stopped),
    .fan_on_o           (fan_on),
    .measured_current_o (measured_current),
    .filtered_voltage_o (filtered_voltage)
  );

  // result word, lowest field first
  assign m_axis_tdata_o = {7'b0, filtered_voltage, measured_current,
                           fan_on, stopped, pwm_duty};

endmodule

[sim/load_current_regulator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_current_regulator_checker: result predictor and scoreboard
// mirrors the register file and the control state of the regulator, predicts
// one result word per accepted sample word and compares it field by field
// ----------------------------------------------------------------------------
module load_current_regulator_checker
  import lcr_pkg::*;
#(
  parameter int unsigned DUTY_LIMIT = 4000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // current_sample[11:0], voltage_sample[23:12], temperature[35:24], zero pad
  input  logic [39:0]          s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // pwm_duty[11:0], stopped[12], fan_on[13], measured_current[26:14],
  // filtered_voltage[40:27], zero pad
  input  logic [47:0]          m_tdata_i,
  output int                   fail_cnt_o,
  output int                   pending_o,
  output int                   result_cnt_o,
  output int                   fan_cnt_o,
  output int                   stop_cnt_o,
  output int                   clamp_cnt_o,
  output int                   floor_cnt_o
);

  localparam int CUTOFF_BIT  = 0;
  localparam int THERMAL_BIT = 1;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [3:0]         pad;
    logic signed [11:0] temp;
    logic [11:0]        volt;
    logic [11:0]        amp;
  } tick_word_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic [13:0]        volts;
    logic signed [12:0] amps;
    logic               fan;
    logic               stopped;
    logic [11:0]        duty;
  } report_word_t;

  // register mirror
  longint     sp_cnt, offs_cnt, gain_q8, comp_q8, cut_cnt, trip_cnt, rel_cnt;
  logic [1:0] feat;

  // regulator state, q8 where noted
  longint cf_q8, vf_q8, acc_q8, base_temp;
  bit     stop_hold, base_ok, fan_hot;

  report_word_t pending_reports[$];
  report_word_t got, want;

  function automatic report_word_t step_regulator(input tick_word_t w);
    longint       amp, volt, temp, target, dev, thr, vcnt;
    report_word_t r;
    amp  = longint'(w.amp);
    volt = longint'(w.volt);
    temp = longint'($signed(w.temp));
    if (!stop_hold) begin
      cf_q8  += ((amp - offs_cnt) * 256 - cf_q8) / 10;
      target  = 2 * volt * 256 + ((comp_q8 * cf_q8) >>> 8);
      vf_q8  += ((target - vf_q8) * 2) / 3;
      acc_q8 += (gain_q8 * (sp_cnt * 256 - cf_q8)) >>> 8;
      if (acc_q8 < 0 || cf_q8 < 0 || sp_cnt == 0) acc_q8 = 0;
      if (acc_q8 > longint'(DUTY_LIMIT) * 256) acc_q8 = longint'(DUTY_LIMIT) * 256;
      if (feat[CUTOFF_BIT] && sp_cnt > 0 && vf_q8 <= cut_cnt * 256) begin
        acc_q8    = 0;
        stop_hold = 1'b1;
      end
      if (!base_ok) begin
        base_temp = temp;
        base_ok   = 1'b1;
      end else if (feat[THERMAL_BIT]) begin
        dev = base_temp - temp;
        if (dev < 0) dev = -dev;
        thr = fan_hot ? rel_cnt : trip_cnt;
        if (dev > thr) begin
          acc_q8  = 0;
          fan_hot = 1'b1;
        end else begin
          fan_hot = 1'b0;
        end
      end else begin
        fan_hot = 1'b0;
      end
    end
    vcnt = vf_q8 >>> 8;
    if (vcnt < 0) vcnt = 0;
    if (vcnt > 16383) vcnt = 16383;
    r         = '0;
    r.duty    = 12'(acc_q8 >>> 8);
    r.stopped = stop_hold;
    r.fan     = fan_hot;
    r.amps    = 13'(cf_q8 >>> 8);
    r.volts   = 14'(vcnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_cnt = 0; offs_cnt = 0; gain_q8 = 63; comp_q8 = 0;
      cut_cnt = 3008; trip_cnt = 16; rel_cnt = 8; feat = '0;
      cf_q8 = 0; vf_q8 = 0; acc_q8 = 0; base_temp = 0;
      stop_hold = 1'b0; base_ok = 1'b0; fan_hot = 1'b0;
      pending_reports.delete();
      fail_cnt_o = 0; pending_o = 0; result_cnt_o = 0;
      fan_cnt_o = 0; stop_cnt_o = 0; clamp_cnt_o = 0; floor_cnt_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = report_word_t'(m_tdata_i);
        result_cnt_o++;
        if (pending_reports.size() == 0) begin
          if (fail_cnt_o < REPORT_MAX)
            $display("%0t: result word %h with nothing outstanding", $realtime, m_tdata_i);
          fail_cnt_o++;
        end else begin
          want = pending_reports.pop_front();
          if (got.duty !== want.duty || got.stopped !== want.stopped ||
              got.fan !== want.fan || got.amps !== want.amps ||
              got.volts !== want.volts) begin
            if (fail_cnt_o < REPORT_MAX)
              $display({"%0t: duty %0d/%0d stopped %0b/%0b fan %0b/%0b ",
                        "current %0d/%0d voltage %0d/%0d (expected/actual)"},
                       $realtime, want.duty, got.duty, want.stopped, got.stopped,
                       want.fan, got.fan, want.amps, got.amps, want.volts, got.volts);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SETPOINT:      sp_cnt   = longint'(cfg_data_i[11:0]);
          REG_SENSE_OFFSET:  offs_cnt = longint'(cfg_data_i[11:0]);
          REG_LOOP_GAIN:     gain_q8  = longint'(cfg_data_i[9:0]);
          REG_VOLT_COMP:     comp_q8  = longint'($signed(cfg_data_i[9:0]));
          REG_CUTOFF_LEVEL:  cut_cnt  = longint'(cfg_data_i[13:0]);
          REG_TRIP_DELTA:    trip_cnt = longint'(cfg_data_i[7:0]);
          REG_RELEASE_DELTA: rel_cnt  = longint'(cfg_data_i[7:0]);
          REG_FEATURES:      feat     = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        want = step_regulator(tick_word_t'(s_tdata_i));
        pending_reports.push_back(want);
        if (want.fan) fan_cnt_o++;
        if (want.stopped) stop_cnt_o++;
        if (acc_q8 == longint'(DUTY_LIMIT) * 256) clamp_cnt_o++;
        if (vf_q8 < 0) floor_cnt_o++;
      end
      pending_o = pending_reports.size();
    end
  end

endmodule

[sim/load_current_regulator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_current_regulator_tb: stimulus and verdict for the load current regulator
// a directed opening hits the field extremes and the protection corner cases,
// then randomly configured phases of regulated sample runs follow, ending with
// a falling supply that latches the voltage cutoff; the checker scores results
// ----------------------------------------------------------------------------
module load_current_regulator_tb;
  import lcr_pkg::*;

  localparam int unsigned DUTY_LIMIT     = 4000;
  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 6;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          DRAIN_CYCLES   = 24;
  localparam int          WATCHDOG_LIMIT = 2000; // cycles with no word moving
  localparam int          RANDOM_TARGET  = 1780; // words before the cutoff run
  localparam int          BASE_TEMP      = 400;  // first tick sets the baseline
  localparam int          TEMP_LO        = -880;
  localparam int          TEMP_HI        = 2000;

  localparam logic [1:0] FEAT_NONE    = 2'b00;
  localparam logic [1:0] FEAT_CUTOFF  = 2'b01;
  localparam logic [1:0] FEAT_THERMAL = 2'b10;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready at random
    RX_EVERY4,  // ready one cycle in four
    RX_STARVE   // long stalls with single ready cycles
  } rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;

  int fail_cnt, pending, result_cnt, fan_cnt, stop_cnt, clamp_cnt, floor_cnt;

  int words_sent = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int temp_now   = BASE_TEMP;
  int idle_cycles = 0;

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_run  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  load_current_regulator #(
    .PWM_LIMIT(DUTY_LIMIT)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  load_current_regulator_checker #(
    .DUTY_LIMIT(DUTY_LIMIT)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .result_cnt_o(result_cnt),
    .fan_cnt_o   (fan_cnt),
    .stop_cnt_o  (stop_cnt),
    .clamp_cnt_o (clamp_cnt),
    .floor_cnt_o (floor_cnt)
  );

  // result side back-pressure, switching to a new random pattern after a random run
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 400);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_EVERY4: m_tready <= (rx_left % 4 == 0);
      default: begin
        if (rx_run == 0) begin
          m_tready <= 1'b1;
          rx_run = $urandom_range(1, 40);
        end else begin
          m_tready <= 1'b0;
          rx_run--;
        end
      end
    endcase
  end

  // watchdog: nothing moving on either stream for too long ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("load_current_regulator: mismatch");
      $finish;
    end
  end

  // one sample word; bursts of random length separated by random gaps,
  // valid stays high between words of a burst
  task automatic push_tick(input logic [11:0] amp, input logic [11:0] volt,
                           input logic signed [11:0] temp);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, temp, volt, amp};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    words_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(value);
    @(posedge clk);
    reg_writes++;
  endtask

  // full register set, only once the block has drained
  task automatic write_regs(input int sp, input int off, input int gain, input int vc,
                            input int cut, input int trip, input int rel,
                            input logic [1:0] feat);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_SENSE_OFFSET, off);
    write_reg(REG_LOOP_GAIN, gain);
    write_reg(REG_VOLT_COMP, vc & 'h3FF);   // 10-bit two's complement
    write_reg(REG_CUTOFF_LEVEL, cut);
    write_reg(REG_TRIP_DELTA, trip);
    write_reg(REG_RELEASE_DELTA, rel);
    write_reg(REG_FEATURES, int'(feat));
    cfg_we <= 1'b0;
  endtask

  // range ends now and then, otherwise a value in the usual span
  function automatic int pick_edge(input int lo, input int hi, input int typ_hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return lo + int'($urandom_range(0, typ_hi - lo));
    endcase
  endfunction

  // one randomly configured phase of sample words; the cutoff is only armed
  // where the voltage provably stays above its level (or the setpoint is 0),
  // because a latched stop can only be cleared by reset
  task automatic random_phase(input int n);
    int         sp, off, gain, vc, cut, trip, rel;
    int         spread, vlo, vhi, hot_band, amp, volt, temp;
    logic [1:0] feat;
    bit         guarded;
    sp   = pick_edge(0, 4095, ($urandom_range(0, 1) == 0) ? 800 : 4095);
    off  = pick_edge(0, 4095, 600);
    gain = pick_edge(0, 1023, 160);
    trip = pick_edge(0, 255, 64);
    rel  = pick_edge(0, 255, 64);
    feat = ($urandom_range(0, 1) == 0) ? FEAT_THERMAL : FEAT_NONE;
    guarded = (sp != 0) && ($urandom_range(0, 2) == 0);
    if (guarded) begin
      // small compensation and supply above 1024 keep the target over the level
      vc  = int'($urandom_range(0, 64)) - 32;
      cut = $urandom_range(0, 1400);
      vlo = 1024;
      vhi = 4095;
    end else begin
      vc  = pick_edge(-512, 511, 511);
      cut = pick_edge(0, 16383, 16383);
      case ($urandom_range(0, 2))
        0:       begin vlo = 0;    vhi = 200;  end  // low supply, filter can go negative
        1:       begin vlo = 0;    vhi = 4095; end
        default: begin vlo = 3000; vhi = 4095; end
      endcase
      if (sp == 0 && $urandom_range(0, 1) == 0) feat |= FEAT_CUTOFF;
    end
    case ($urandom_range(0, 3))
      0:       spread = 3;
      1:       spread = 30;
      2:       spread = 300;
      default: spread = 4095;
    endcase
    hot_band = ((trip > rel) ? trip : rel) + 24;

    write_regs(sp, off, gain, vc, cut, trip, rel, feat);
    if (guarded) begin
      // pull the voltage filter up to full supply before arming the cutoff
      repeat (4) push_tick(12'(off), 12'hFFF, 12'(temp_now));
      write_regs(sp, off, gain, vc, cut, trip, rel, feat | FEAT_CUTOFF);
    end

    repeat (n) begin
      // current hovers around offset plus setpoint so the error changes sign
      if ($urandom_range(0, 24) == 0)
        amp = $urandom_range(0, 4095);
      else
        amp = off + sp + int'($urandom_range(0, 2 * spread)) - spread;
      if (amp < 0) amp = 0;
      if (amp > 4095) amp = 4095;
      volt = $urandom_range(vlo, vhi);
      // temperature drifts around the baseline across both thresholds
      if ($urandom_range(0, 19) == 0) begin
        temp = TEMP_LO + int'($urandom_range(0, TEMP_HI - TEMP_LO));  // stray reading
      end else begin
        if ($urandom_range(0, 39) == 0)
          temp_now = BASE_TEMP + int'($urandom_range(0, 2 * hot_band)) - hot_band;
        else
          temp_now += int'($urandom_range(0, 10)) - 5;
        if (temp_now > BASE_TEMP + hot_band) temp_now = BASE_TEMP + hot_band;
        if (temp_now < BASE_TEMP - hot_band) temp_now = BASE_TEMP - hot_band;
        if (temp_now > TEMP_HI) temp_now = TEMP_HI;
        if (temp_now < TEMP_LO) temp_now = TEMP_LO;
        temp = temp_now;
      end
      push_tick(12'(amp), 12'(volt), 12'(temp));
    end
  endtask

  initial begin
    int k, amp, volt;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, first tick sets the temperature baseline,
    // thermal check off so large swings keep the fan off
    push_tick(12'd0, 12'd0, 12'(BASE_TEMP));
    push_tick(12'hFFF, 12'hFFF, 12'(TEMP_HI));
    push_tick(12'd0, 12'hFFF, 12'(TEMP_LO));

    // full setpoint and gain drive the accumulator into its clamp;
    // zero thresholds: no rise stays clear, one count trips, back to zero releases
    write_regs(4095, 0, 1023, 511, 0, 0, 0, FEAT_THERMAL);
    push_tick(12'hFFF, 12'hFFF, 12'(BASE_TEMP));
    push_tick(12'hFFF, 12'hFFF, 12'(BASE_TEMP + 1));
    push_tick(12'hFFF, 12'hFFF, 12'(BASE_TEMP));
    push_tick(12'd0, 12'd0, 12'h800);              // most negative temperature
    push_tick(12'd0, 12'd0, 12'h7FF);              // most positive temperature

    // offset above the sample: negative current zeroes the drive, positive
    // compensation of a negative current pulls the voltage below zero
    write_regs(1, 4095, 1023, 511, 16383, 255, 255, FEAT_NONE);
    repeat (3) push_tick(12'd0, 12'd0, 12'(BASE_TEMP));

    // widest thresholds: a rise of exactly 255 holds, 256 trips, 255 releases
    write_regs(4095, 0, 1023, -512, 0, 255, 255, FEAT_THERMAL);
    push_tick(12'hFFF, 12'd0, 12'(BASE_TEMP + 255));
    push_tick(12'hFFF, 12'd0, 12'(BASE_TEMP + 256));
    push_tick(12'hFFF, 12'd0, 12'(BASE_TEMP - 255));
    push_tick(12'd0, 12'hFFF, 12'(BASE_TEMP));

    // random phases
    while (words_sent < RANDOM_TARGET)
      random_phase($urandom_range(40, 120));

    // falling supply with the cutoff armed: the stop latches partway down and
    // the remaining ticks must repeat the frozen values with the drive at zero
    write_regs(2000, 0, 63, 0, 1500, 255, 255, FEAT_THERMAL);
    repeat (4) push_tick(12'd2000, 12'hFFF, 12'(BASE_TEMP));
    write_regs(2000, 0, 63, 0, 1500, 255, 255, FEAT_CUTOFF | FEAT_THERMAL);
    for (k = 0; k < 120; k++) begin
      volt = 4095 - 40 * k;
      if (volt < 0) volt = 0;
      amp = 2000 + int'($urandom_range(0, 40)) - 20;
      push_tick(12'(amp), 12'(volt), 12'(BASE_TEMP + int'($urandom_range(0, 8)) - 4));
    end

    // drain, then give late or extra words a chance to show up
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sample words, %0d result words, %0d register writes",
             words_sent, result_cnt, reg_writes);
    $display("fan on %0d, stopped %0d, drive at limit %0d, voltage floored at zero %0d",
             fan_cnt, stop_cnt, clamp_cnt, floor_cnt);
    if (fail_cnt == 0) begin
      $display("load_current_regulator: match");
    end else begin
      $display("%0d failing result words", fail_cnt);
      $display("load_current_regulator: mismatch");
    end
    $finish;
  end

endmodule
